// File: rtl/core/tbj_pkg.sv
// package for the two-bank record journal
// shared constants and the bytewise crc-32 step; no dependencies
package tbj_pkg;

   localparam int TBJ_BANK_DEPTH = 256;
   localparam int TBJ_REC_W = 128;
   localparam int TBJ_CRC_SPAN = 12;
   localparam logic [31:0] TBJ_CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] TBJ_CRC_ONES = 32'hFFFFFFFF;
   localparam logic [7:0] TBJ_SLOT_NONE = 8'hFF;
   localparam logic [7:0] TBJ_SLOT_HIGHEST = 8'h01;

   localparam logic [1:0] TBJ_CMD_READ = 2'd0;
   localparam logic [1:0] TBJ_CMD_WRITE = 2'd1;
   localparam logic [1:0] TBJ_CMD_PRELOAD = 2'd2;
   localparam logic [1:0] TBJ_CMD_USED = 2'd3;

   // one byte into a reflected crc register, eight shift steps
   function automatic logic [31:0] crc_byte(input logic [31:0] c_i, input logic [7:0] b_i);
      logic [31:0] c;
      c = c_i ^ {24'd0, b_i};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ TBJ_CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/core/two_bank_crc_record_journal.sv
// top level of the two-bank record journal: sequencer, scan and result register
// uses tbj_pkg, tbj_mem and tbj_crc_pipe
//
//  channel | direction | ports
//  req     | in        | req_valid/req_stall, command, bank, slot, raw record, slot bytes
//  rsp     | out       | rsp_valid/rsp_stall, found, seq, slot bytes, bank, index, used, erased
//
// read, write and used query scan all 2*N records through the memory read port and the
// crc pipeline; a write also erases the target bank when needed and sends the new record
// through the crc pipeline before it programs it. preload goes straight to the result.
// after reset a clearing pass writes all 2*N records to ones (no transfer).
// one command at a time; a finished result waits in the output register while rsp stalls.
module two_bank_crc_record_journal #(
   parameter int BANK_DEPTH = tbj_pkg::TBJ_BANK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic        req_bank_sel,
   input  logic [7:0]  req_slot_index,
   input  logic [63:0] req_raw_low,
   input  logic [63:0] req_raw_high,
   input  logic [7:0]  req_active_slot,
   input  logic [7:0]  req_pending_slot,
   input  logic [7:0]  req_attempt_count,
   input  logic [7:0]  req_confirmed_flag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_seq_number,
   output logic [7:0]  rsp_out_active,
   output logic [7:0]  rsp_out_pending,
   output logic [7:0]  rsp_out_attempts,
   output logic [7:0]  rsp_out_confirmed,
   output logic        rsp_out_bank,
   output logic [7:0]  rsp_out_index,
   output logic [8:0]  rsp_used_count,
   output logic        rsp_bank_erased
);

   localparam int N  = BANK_DEPTH;
   localparam int IW = $clog2(N);
   localparam int AW = IW + 1;
   localparam int RW = tbj_pkg::TBJ_REC_W;

   localparam logic [2:0] ST_CLR    = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_ERASE  = 3'd4;
   localparam logic [2:0] ST_CRC    = 3'd5;
   localparam logic [2:0] ST_PROG   = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   localparam logic [AW:0]   LAST_ALL   = (AW+1)'(2 * N - 1);
   localparam logic [AW:0]   LAST_BANK  = (AW+1)'(N - 1);
   localparam logic [IW:0]   FULL       = (IW+1)'(N);
   // bank 1 starts right after bank 0, address is base plus index
   localparam logic [AW-1:0] BANK1_BASE = AW'(N);

   logic [2:0]    state_ff, state_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          rd_issue_ff, rd_issue_in;
   logic [AW-1:0] rd_addr_ff;
   logic          sent_ff, sent_in;

   logic [1:0] cmd_ff;
   logic       bsel_ff;
   logic [7:0] act_ff, pend_ff, att_ff, conf_ff;

   logic        have_ff [2];
   logic [IW:0] used_ff [2];
   logic [31:0] bseq_ff [2];
   logic [7:0]  bact_ff [2], bpend_ff [2], batt_ff [2], bconf_ff [2];

   logic          tgt_ff;
   logic [IW-1:0] widx_ff;
   logic [31:0]   crc_new_ff;

   // result held until the output register is free
   logic        res_found_ff, res_bank_ff, res_erased_ff;
   logic [31:0] res_seq_ff;
   logic [7:0]  res_act_ff, res_pend_ff, res_att_ff, res_conf_ff, res_index_ff;
   logic [8:0]  res_used_ff;

   logic        rsp_valid_ff, rsp_found_ff, rsp_bank_ff, rsp_erased_ff;
   logic [31:0] rsp_seq_ff;
   logic [7:0]  rsp_act_ff, rsp_pend_ff, rsp_att_ff, rsp_conf_ff, rsp_index_ff;
   logic [8:0]  rsp_used_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic [RW-1:0] rd_data;
   logic [AW-1:0] rd_addr;

   logic          p_in_valid, p_in_bank;
   logic [IW-1:0] p_in_idx;
   logic [RW-1:0] p_in_rec;
   logic          p_out_valid, p_out_bank;
   logic [IW-1:0] p_out_idx;
   logic [RW-1:0] p_out_rec;
   logic [31:0]   p_out_crc;

   logic          accept, preload_hit, scan_last, out_free;
   logic          rec_blank, rec_good;
   logic [RW-1:0] new_rec;

   logic          cur_have, cur_bank;
   logic [31:0]   cur_seq, nseq;
   logic [7:0]    cur_act, cur_pend, cur_att, cur_conf;
   logic          d_tgt, d_erase;
   logic [IW:0]   d_idx;

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign preload_hit = (32'(req_slot_index) < N);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   assign new_rec = {crc_new_ff, tbj_pkg::TBJ_CRC_ONES, conf_ff, att_ff, pend_ff, act_ff,
                     res_seq_ff};

   tbj_mem #(.DEPTH(2 * N), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tbj_crc_pipe #(.IW(IW)) u_crc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_in_valid),
      .in_bank   (p_in_bank),
      .in_idx    (p_in_idx),
      .in_rec    (p_in_rec),
      .out_valid (p_out_valid),
      .out_bank  (p_out_bank),
      .out_idx   (p_out_idx),
      .out_rec   (p_out_rec),
      .out_crc   (p_out_crc)
   );

   // pipeline input: scanned record, or the new record during the crc step
   always_comb begin
      rd_addr = cnt_ff[AW-1:0];
      if (state_ff == ST_CRC) begin
         p_in_valid = !sent_ff;
         p_in_rec   = {32'd0, new_rec[95:0]};
      end else begin
         p_in_valid = rd_issue_ff;
         p_in_rec   = rd_data;
      end
      p_in_bank = (rd_addr_ff >= BANK1_BASE);
      p_in_idx  = IW'(rd_addr_ff - (p_in_bank ? BANK1_BASE : '0));
   end

   assign rec_blank = &p_out_rec;
   assign rec_good  = !rec_blank && (p_out_crc == p_out_rec[127:96])
                      && (p_out_rec[39:32] <= tbj_pkg::TBJ_SLOT_HIGHEST)
                      && ((p_out_rec[47:40] <= tbj_pkg::TBJ_SLOT_HIGHEST)
                          || (p_out_rec[47:40] == tbj_pkg::TBJ_SLOT_NONE));
   assign scan_last = p_out_valid && p_out_bank && (p_out_idx == IW'(N - 1));

   // current record and write target, from the scan summary
   always_comb begin
      cur_have = 1'b1;
      cur_bank = 1'b0;
      cur_seq  = bseq_ff[0];
      cur_act  = bact_ff[0];
      cur_pend = bpend_ff[0];
      cur_att  = batt_ff[0];
      cur_conf = bconf_ff[0];
      priority if (have_ff[0] && (!have_ff[1] || bseq_ff[0] >= bseq_ff[1])) begin
         cur_bank = 1'b0;
      end else if (have_ff[1]) begin
         cur_bank = 1'b1;
         cur_seq  = bseq_ff[1];
         cur_act  = bact_ff[1];
         cur_pend = bpend_ff[1];
         cur_att  = batt_ff[1];
         cur_conf = bconf_ff[1];
      end else begin
         cur_have = 1'b0;
         cur_seq  = 32'd0;
         cur_act  = 8'd0;
         cur_pend = tbj_pkg::TBJ_SLOT_NONE;
         cur_att  = 8'd0;
         cur_conf = 8'd0;
      end
      nseq = cur_seq + 32'd1;
      if (!cur_have) begin
         d_tgt   = 1'b0;
         d_erase = (used_ff[0] != '0);
         d_idx   = '0;
      end else if (used_ff[cur_bank] == FULL) begin
         d_tgt   = !cur_bank;
         d_erase = 1'b1;
         d_idx   = '0;
      end else begin
         d_tgt   = cur_bank;
         d_erase = 1'b0;
         d_idx   = used_ff[cur_bank];
      end
   end

   // memory write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = '1;
      unique case (state_ff)
         ST_CLR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            wr_en   = accept && (req_command == tbj_pkg::TBJ_CMD_PRELOAD) && preload_hit;
            wr_addr = (req_bank_sel ? BANK1_BASE : '0) + AW'(req_slot_index);
            wr_data = {req_raw_high, req_raw_low};
         end
         ST_ERASE: begin
            wr_en   = 1'b1;
            wr_addr = (tgt_ff ? BANK1_BASE : '0) + {1'b0, cnt_ff[IW-1:0]};
         end
         ST_PROG: begin
            wr_en   = 1'b1;
            wr_addr = (tgt_ff ? BANK1_BASE : '0) + {1'b0, widx_ff};
            wr_data = new_rec;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rd_issue_in = 1'b0;
      sent_in     = sent_ff;
      unique case (state_ff)
         ST_CLR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ALL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = (req_command == tbj_pkg::TBJ_CMD_PRELOAD) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff <= LAST_ALL) begin
               rd_issue_in = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
            end
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cnt_in  = '0;
            sent_in = 1'b0;
            if (cmd_ff == tbj_pkg::TBJ_CMD_WRITE) begin
               state_in = d_erase ? ST_ERASE : ST_CRC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ERASE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BANK) begin
               state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            sent_in = 1'b1;
            if (p_out_valid) begin
               state_in = ST_PROG;
            end
         end
         ST_PROG: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         rd_issue_ff  <= 1'b0;
         sent_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         rd_issue_ff <= rd_issue_in;
         sent_ff     <= sent_in;
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      rd_addr_ff <= cnt_ff[AW-1:0];

      if (accept) begin
         cmd_ff        <= req_command;
         bsel_ff       <= req_bank_sel;
         act_ff        <= req_active_slot;
         pend_ff       <= req_pending_slot;
         att_ff        <= req_attempt_count;
         conf_ff       <= req_confirmed_flag;
         res_found_ff  <= 1'b0;
         res_seq_ff    <= '0;
         res_act_ff    <= '0;
         res_pend_ff   <= tbj_pkg::TBJ_SLOT_NONE;
         res_att_ff    <= '0;
         res_conf_ff   <= '0;
         res_bank_ff   <= 1'b0;
         res_index_ff  <= '0;
         res_used_ff   <= '0;
         res_erased_ff <= 1'b0;
         for (int b = 0; b < 2; b++) begin
            have_ff[b] <= 1'b0;
            used_ff[b] <= '0;
         end
      end

      // scan summary, records arrive in address order so the earliest wins a tie
      if (state_ff == ST_SCAN && p_out_valid) begin
         if (!rec_blank) begin
            used_ff[p_out_bank] <= {1'b0, p_out_idx} + 1'b1;
         end
         if (rec_good && (!have_ff[p_out_bank] || p_out_rec[31:0] > bseq_ff[p_out_bank])) begin
            have_ff[p_out_bank]  <= 1'b1;
            bseq_ff[p_out_bank]  <= p_out_rec[31:0];
            bact_ff[p_out_bank]  <= p_out_rec[39:32];
            bpend_ff[p_out_bank] <= p_out_rec[47:40];
            batt_ff[p_out_bank]  <= p_out_rec[55:48];
            bconf_ff[p_out_bank] <= p_out_rec[63:56];
         end
      end

      if (state_ff == ST_DECIDE) begin
         unique case (cmd_ff)
            tbj_pkg::TBJ_CMD_READ: begin
               res_found_ff <= cur_have;
               res_seq_ff   <= cur_seq;
               res_act_ff   <= cur_act;
               res_pend_ff  <= cur_pend;
               res_att_ff   <= cur_att;
               res_conf_ff  <= cur_conf;
               res_bank_ff  <= cur_have && cur_bank;
            end
            tbj_pkg::TBJ_CMD_WRITE: begin
               res_found_ff  <= 1'b1;
               res_seq_ff    <= nseq;
               res_act_ff    <= act_ff;
               res_pend_ff   <= pend_ff;
               res_att_ff    <= att_ff;
               res_conf_ff   <= conf_ff;
               res_bank_ff   <= d_tgt;
               res_index_ff  <= 8'(d_idx);
               res_erased_ff <= d_erase;
               tgt_ff        <= d_tgt;
               widx_ff       <= d_idx[IW-1:0];
            end
            tbj_pkg::TBJ_CMD_USED: begin
               res_used_ff <= 9'(used_ff[bsel_ff]);
            end
            default: begin
               res_found_ff <= 1'b0;
            end
         endcase
      end

      if (state_ff == ST_CRC && p_out_valid) begin
         crc_new_ff <= p_out_crc;
      end

      if (state_ff == ST_DONE && out_free) begin
         rsp_found_ff  <= res_found_ff;
         rsp_seq_ff    <= res_seq_ff;
         rsp_act_ff    <= res_act_ff;
         rsp_pend_ff   <= res_pend_ff;
         rsp_att_ff    <= res_att_ff;
         rsp_conf_ff   <= res_conf_ff;
         rsp_bank_ff   <= res_bank_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_used_ff   <= res_used_ff;
         rsp_erased_ff <= res_erased_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_seq_number    = rsp_seq_ff;
   assign rsp_out_active    = rsp_act_ff;
   assign rsp_out_pending   = rsp_pend_ff;
   assign rsp_out_attempts  = rsp_att_ff;
   assign rsp_out_confirmed = rsp_conf_ff;
   assign rsp_out_bank      = rsp_bank_ff;
   assign rsp_out_index     = rsp_index_ff;
   assign rsp_used_count    = rsp_used_ff;
   assign rsp_bank_erased   = rsp_erased_ff;

endmodule

// File: rtl/core/tbj_mem.sv
// record store: one write port, one registered read port
// depends on tbj_pkg for the record width
module tbj_mem #(
   parameter int DEPTH = 2 * tbj_pkg::TBJ_BANK_DEPTH,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [tbj_pkg::TBJ_REC_W-1:0] wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [tbj_pkg::TBJ_REC_W-1:0] rd_data
);

   logic [tbj_pkg::TBJ_REC_W-1:0] mem [DEPTH];
   logic [tbj_pkg::TBJ_REC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tbj_crc_pipe.sv
// twelve-stage crc-32 pipeline, one record byte per stage
// carries the record and its position along; depends on tbj_pkg
module tbj_crc_pipe #(
   parameter int IW = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic                          in_bank,
   input  logic [IW-1:0]                 in_idx,
   input  logic [tbj_pkg::TBJ_REC_W-1:0] in_rec,
   output logic                          out_valid,
   output logic                          out_bank,
   output logic [IW-1:0]                 out_idx,
   output logic [tbj_pkg::TBJ_REC_W-1:0] out_rec,
   output logic [31:0]                   out_crc
);

   localparam int NS = tbj_pkg::TBJ_CRC_SPAN;

   logic                          valid_ff [NS];
   logic                          bank_ff  [NS];
   logic [IW-1:0]                 idx_ff   [NS];
   logic [tbj_pkg::TBJ_REC_W-1:0] rec_ff   [NS];
   logic [31:0]                   crc_ff   [NS];
   logic [31:0]                   crc_in   [NS];

   always_comb begin
      crc_in[0] = tbj_pkg::crc_byte(tbj_pkg::TBJ_CRC_ONES, in_rec[7:0]);
      for (int k = 1; k < NS; k++) begin
         crc_in[k] = tbj_pkg::crc_byte(crc_ff[k-1], rec_ff[k-1][8*k +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
      bank_ff[0] <= in_bank;
      idx_ff[0]  <= in_idx;
      rec_ff[0]  <= in_rec;
      crc_ff[0]  <= crc_in[0];
      for (int k = 1; k < NS; k++) begin
         bank_ff[k] <= bank_ff[k-1];
         idx_ff[k]  <= idx_ff[k-1];
         rec_ff[k]  <= rec_ff[k-1];
         crc_ff[k]  <= crc_in[k];
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_bank  = bank_ff[NS-1];
   assign out_idx   = idx_ff[NS-1];
   assign out_rec   = rec_ff[NS-1];
   assign out_crc   = crc_ff[NS-1] ^ tbj_pkg::TBJ_CRC_ONES;

endmodule
